FILE: hw/rtl/ptc_pkg.sv
package ptc_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned CNT_W = 6;
    localparam int unsigned CFG_W = 48;
    localparam int unsigned RAW_W = 20;
    localparam int unsigned HALF_W = 32;

    localparam logic [WORD_W-1:0] TEMP_OFFSET = 64'd128000;
    localparam logic [WORD_W-1:0] PRESS_FULL = 64'd1048576;
    localparam logic [WORD_W-1:0] PRESS_SCALE = 64'd3125;
    localparam logic [WORD_W-1:0] TEMP_ROUND = 64'd128;
    localparam logic [WORD_W-1:0] DIV_BIAS = 64'h0000_8000_0000_0000;

    typedef enum logic [1:0] {
        CFG_TEMP    = 2'd0,
        CFG_PRESS_A = 2'd1,
        CFG_PRESS_B = 2'd2,
        CFG_PRESS_C = 2'd3
    } cfg_index_t;

    typedef enum logic {
        OP_TEMP  = 1'b0,
        OP_PRESS = 1'b1
    } op_t;

    typedef struct packed {
        logic              operation;
        logic [RAW_W-1:0]  raw_sample;
    } in_item_t;

    typedef struct packed {
        logic                result_kind;
        logic signed [31:0]  temperature_centi;
        logic [31:0]         pressure_q24_8;
        logic                zero_divisor;
    } out_item_t;

    function automatic logic [WORD_W-1:0] wrap32(input logic [WORD_W-1:0] v);
        return {{HALF_W{v[HALF_W-1]}}, v[HALF_W-1:0]};
    endfunction

    function automatic logic [WORD_W-1:0] asr(input logic [WORD_W-1:0] v,
                                              input logic [CNT_W-1:0] s);
        return WORD_W'($signed(v) >>> s);
    endfunction

    function automatic logic [WORD_W-1:0] lane_u(input logic [CFG_W-1:0] r,
                                                 input logic [1:0] k);
        return {48'd0, r[16*k +: 16]};
    endfunction

    function automatic logic [WORD_W-1:0] lane_s(input logic [CFG_W-1:0] r,
                                                 input logic [1:0] k);
        logic [15:0] v;
        v = r[16*k +: 16];
        return {{48{v[15]}}, v};
    endfunction

endpackage

FILE: hw/rtl/ptc_mul.sv
module ptc_mul (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [ptc_pkg::WORD_W-1:0] op_a,
    input  logic [ptc_pkg::WORD_W-1:0] op_b,
    output logic                       done,
    output logic [ptc_pkg::WORD_W-1:0] product
);
    import ptc_pkg::*;

    logic [WORD_W-1:0] a_reg, a_next;
    logic [WORD_W-1:0] b_reg, b_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    // shift-add, one multiplier bit per cycle, low 64 bits kept
    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next = op_a;
            b_next = op_b;
            acc_next = '0;
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_next = acc_reg + a_reg;
            end
            a_next = {a_reg[WORD_W-2:0], 1'b0};
            b_next = {1'b0, b_reg[WORD_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (&cnt_reg) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        a_reg <= a_next;
        b_reg <= b_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign product = acc_reg;

endmodule

FILE: hw/rtl/ptc_div.sv
module ptc_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [ptc_pkg::WORD_W-1:0] dividend,
    input  logic [ptc_pkg::WORD_W-1:0] divisor,
    output logic                       done,
    output logic [ptc_pkg::WORD_W-1:0] quotient
);
    import ptc_pkg::*;

    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] den_reg, den_next;
    logic [WORD_W-1:0] res_reg, res_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic              busy_reg, busy_next;
    logic              fix_reg, fix_next;
    logic              done_reg, done_next;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   trial;

    assign shifted = {rem_reg, quo_reg[WORD_W-1]};
    assign trial = shifted - {1'b0, den_reg};

    // restoring division on magnitudes, one quotient bit per cycle
    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        res_next = res_reg;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        busy_next = busy_reg;
        fix_next = 1'b0;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            quo_next = dividend[WORD_W-1] ? (~dividend + 1'b1) : dividend;
            den_next = divisor[WORD_W-1] ? (~divisor + 1'b1) : divisor;
            neg_next = dividend[WORD_W-1] ^ divisor[WORD_W-1];
            cnt_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[WORD_W]) begin
                rem_next = trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (&cnt_reg) begin
                busy_next = 1'b0;
                fix_next = 1'b1;
            end
        end else if (fix_reg) begin
            res_next = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fix_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            fix_reg <= fix_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        res_reg <= res_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quotient = res_reg;

endmodule

FILE: hw/rtl/pressure_temperature_compensation_top.sv
// channel   direction  handshake                  payload
// s_        in         s_valid / s_ready          s_data (in_item_t)
// m_        out        m_valid / m_ready          m_data (out_item_t)
// cfg_      in         cfg_valid / cfg_ready      cfg_index, cfg_value
// a temperature item uses three serial multiplies
// a pressure item uses ten serial multiplies
// and one serial divide, all on one shift-add and one shift-subtract unit
// one item is worked at a time; s_ready is high while the sequencer is idle
// a finished result waits in the output register while the next item is taken
// reset is synchronous; coefficients and the fine temperature clear to zero
module pressure_temperature_compensation_top (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  ptc_pkg::in_item_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output ptc_pkg::out_item_t        m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  ptc_pkg::cfg_index_t       cfg_index,
    input  logic [ptc_pkg::CFG_W-1:0] cfg_value
);
    import ptc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CALC  = 5'b00010,
        ST_MWAIT = 5'b00100,
        ST_DWAIT = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    typedef enum logic [3:0] {
        SP_T1, SP_T2, SP_T3,
        SP_P1, SP_P2, SP_P3, SP_P4, SP_P5, SP_P6,
        SP_P7, SP_P8, SP_P9, SP_P10, SP_P11, SP_P12
    } step_t;

    state_t            state_reg, state_next;
    step_t             step_reg, step_next;
    logic [CFG_W-1:0]  tc_reg, pa_reg, pb_reg, pc_reg;
    logic [HALF_W-1:0] fine_reg, fine_next;
    logic [RAW_W-1:0]  raw_reg, raw_next;
    logic [WORD_W-1:0] ra_reg, ra_next;
    logic [WORD_W-1:0] rb_reg, rb_next;
    logic [WORD_W-1:0] rp_reg, rp_next;
    logic [WORD_W-1:0] rq_reg, rq_next;
    out_item_t         pend_reg, pend_next;
    out_item_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              mul_start, mul_done, div_start, div_done;
    logic [WORD_W-1:0] mul_a, mul_b, prod, quot;
    logic [WORD_W-1:0] v2, tf, tsum, tcent, psum;

    ptc_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start),
        .op_a(mul_a), .op_b(mul_b), .done(mul_done), .product(prod)
    );

    ptc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(rp_reg), .divisor(ra_reg), .done(div_done), .quotient(quot)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    assign v2 = asr(wrap32(prod), 6'd14);
    assign tf = wrap32(ra_reg + v2);
    assign tsum = wrap32({tf[WORD_W-3:0], 2'b00} + tf + TEMP_ROUND);
    assign tcent = asr(tsum, 6'd8);
    assign psum = asr(rp_reg + ra_reg + rb_reg, 6'd8) + (lane_s(pc_reg, 2'd0) << 4);

    always_comb begin
        state_next = state_reg;
        step_next = step_reg;
        fine_next = fine_reg;
        raw_next = raw_reg;
        ra_next = ra_reg;
        rb_next = rb_reg;
        rp_next = rp_reg;
        rq_next = rq_reg;
        pend_next = pend_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        mul_start = 1'b0;
        div_start = 1'b0;
        mul_a = ra_reg;
        mul_b = rq_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    raw_next = s_data.raw_sample;
                    pend_next = '0;
                    pend_next.result_kind = s_data.operation;
                    ra_next = {{HALF_W{fine_reg[HALF_W-1]}}, fine_reg} - TEMP_OFFSET;
                    step_next = (s_data.operation == OP_PRESS) ? SP_P1 : SP_T1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                state_next = ST_MWAIT;
                unique case (step_reg)
                    SP_T1: begin
                        mul_a = wrap32(64'(raw_reg >> 3) - (lane_u(tc_reg, 2'd0) << 1));
                        mul_b = lane_s(tc_reg, 2'd1);
                    end
                    SP_T2: begin
                        mul_a = wrap32(64'(raw_reg >> 4) - lane_u(tc_reg, 2'd0));
                        mul_b = mul_a;
                    end
                    SP_T3: begin
                        mul_a = rb_reg;
                        mul_b = lane_s(tc_reg, 2'd2);
                    end
                    SP_P1: mul_b = ra_reg;
                    SP_P2: begin
                        mul_a = rq_reg;
                        mul_b = lane_s(pb_reg, 2'd2);
                    end
                    SP_P3: mul_b = lane_s(pb_reg, 2'd1);
                    SP_P4: begin
                        mul_a = rq_reg;
                        mul_b = lane_s(pa_reg, 2'd2);
                    end
                    SP_P5: mul_b = lane_s(pa_reg, 2'd1);
                    SP_P6: begin
                        mul_a = rq_reg;
                        mul_b = lane_u(pa_reg, 2'd0);
                    end
                    SP_P7: begin
                        mul_a = ((PRESS_FULL - 64'(raw_reg)) << 31) - rb_reg;
                        mul_b = PRESS_SCALE;
                    end
                    SP_P8: state_next = ST_DWAIT;
                    SP_P9: begin
                        mul_a = lane_s(pc_reg, 2'd2);
                        mul_b = rq_reg;
                    end
                    SP_P10: mul_b = rq_reg;
                    SP_P11: begin
                        mul_a = lane_s(pc_reg, 2'd1);
                        mul_b = rp_reg;
                    end
                    SP_P12: begin
                        pend_next.pressure_q24_8 = psum[31:0];
                        state_next = ST_DONE;
                    end
                    default: state_next = ST_DONE;
                endcase
                // divisor of zero ends the item without a product
                if (step_reg == SP_P7 && ra_reg == '0) begin
                    pend_next.zero_divisor = 1'b1;
                    state_next = ST_DONE;
                end
                mul_start = (state_next == ST_MWAIT);
                div_start = (state_next == ST_DWAIT);
            end
            ST_MWAIT: begin
                if (mul_done) begin
                    state_next = ST_CALC;
                    step_next = step_t'(step_reg + 1'b1);
                    unique case (step_reg)
                        SP_T1: ra_next = asr(wrap32(prod), 6'd11);
                        SP_T2: rb_next = asr(wrap32(prod), 6'd12);
                        SP_T3: begin
                            fine_next = tf[HALF_W-1:0];
                            pend_next.temperature_centi = tcent[HALF_W-1:0];
                            state_next = ST_DONE;
                        end
                        SP_P1: rq_next = prod;
                        SP_P2: rb_next = prod;
                        SP_P3: rb_next = rb_reg + (prod << 17)
                                         + (lane_s(pb_reg, 2'd0) << 35);
                        SP_P4: rq_next = asr(prod, 6'd8);
                        SP_P5: rq_next = rq_reg + (prod << 12) + DIV_BIAS;
                        SP_P6: ra_next = asr(prod, 6'd33);
                        SP_P7: rp_next = prod;
                        SP_P9: ra_next = prod;
                        SP_P10: ra_next = asr(prod, 6'd25);
                        SP_P11: rb_next = asr(prod, 6'd19);
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_DWAIT: begin
                if (div_done) begin
                    rp_next = quot;
                    rq_next = asr(quot, 6'd13);
                    step_next = SP_P9;
                    state_next = ST_CALC;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    out_next = pend_reg;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg <= SP_T1;
            out_valid_reg <= 1'b0;
            fine_reg <= '0;
            tc_reg <= '0;
            pa_reg <= '0;
            pb_reg <= '0;
            pc_reg <= '0;
        end else begin
            state_reg <= state_next;
            step_reg <= step_next;
            out_valid_reg <= out_valid_next;
            fine_reg <= fine_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_TEMP:    tc_reg <= cfg_value;
                    CFG_PRESS_A: pa_reg <= cfg_value;
                    CFG_PRESS_B: pb_reg <= cfg_value;
                    CFG_PRESS_C: pc_reg <= cfg_value;
                    default: ;
                endcase
            end
        end
        raw_reg <= raw_next;
        ra_reg <= ra_next;
        rb_reg <= rb_next;
        rp_reg <= rp_next;
        rq_reg <= rq_next;
        pend_reg <= pend_next;
        out_reg <= out_next;
    end

endmodule

FILE: sim/tb_pressure_temperature_compensation_top.sv
`timescale 1ns / 100ps

module tb_pressure_temperature_compensation_top;
    import ptc_pkg::*;

    // expected compensation results, in order of acceptance
    class comp_scoreboard;
        logic [47:0] coeff_regs [4];
        logic [31:0] fine_temp;
        out_item_t   pending_q[$];
        int          error_count;

        function new();
            for (int i = 0; i < 4; i++) coeff_regs[i] = '0;
            fine_temp = '0;
            error_count = 0;
        endfunction

        function automatic logic signed [63:0] field_s(logic [47:0] r, int k);
            return {{48{r[16*k+15]}}, r[16*k +: 16]};
        endfunction

        function automatic logic signed [63:0] sext32(logic [63:0] v);
            return {{32{v[31]}}, v[31:0]};
        endfunction

        function void note_config(cfg_index_t idx, logic [47:0] val);
            coeff_regs[idx] = val;
        endfunction

        function void note_input(in_item_t it);
            out_item_t e;
            logic signed [63:0] t1, t2, t3, x, d, y, v1, v2, tf;
            logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
            logic signed [63:0] a, b, p, q, n, den, r;
            logic [63:0] mn, md, uq;
            e = '0;
            e.result_kind = it.operation;
            if (it.operation == OP_TEMP) begin
                t1 = {48'd0, coeff_regs[CFG_TEMP][15:0]};
                t2 = field_s(coeff_regs[CFG_TEMP], 1);
                t3 = field_s(coeff_regs[CFG_TEMP], 2);
                x = sext32({47'd0, it.raw_sample[19:3]} - (t1 << 1));
                x = sext32(x * t2);
                v1 = x >>> 11;
                d = sext32({48'd0, it.raw_sample[19:4]} - t1);
                y = sext32(d * d);
                y = y >>> 12;
                y = sext32(y * t3);
                v2 = y >>> 14;
                tf = sext32(v1 + v2);
                fine_temp = tf[31:0];
                r = sext32(tf * 5 + 128) >>> 8;
                e.temperature_centi = r[31:0];
            end else begin
                p1 = {48'd0, coeff_regs[CFG_PRESS_A][15:0]};
                p2 = field_s(coeff_regs[CFG_PRESS_A], 1);
                p3 = field_s(coeff_regs[CFG_PRESS_A], 2);
                p4 = field_s(coeff_regs[CFG_PRESS_B], 0);
                p5 = field_s(coeff_regs[CFG_PRESS_B], 1);
                p6 = field_s(coeff_regs[CFG_PRESS_B], 2);
                p7 = field_s(coeff_regs[CFG_PRESS_C], 0);
                p8 = field_s(coeff_regs[CFG_PRESS_C], 1);
                p9 = field_s(coeff_regs[CFG_PRESS_C], 2);
                a = sext32({32'd0, fine_temp}) - 64'sd128000;
                b = a * a * p6;
                b = b + ((a * p5) << 17);
                b = b + (p4 << 35);
                a = ((a * a * p3) >>> 8) + ((a * p2) << 12);
                a = (((64'sd1 << 47) + a) * p1) >>> 33;
                if (a == 0) begin
                    e.zero_divisor = 1'b1;
                end else begin
                    p = 64'sd1048576 - {44'd0, it.raw_sample};
                    n = ((p << 31) - b) * 64'sd3125;
                    den = a;
                    // magnitude division truncating toward zero, wraps on min / -1
                    mn = n[63] ? -n : n;
                    md = den[63] ? -den : den;
                    uq = mn / md;
                    p = (n[63] != den[63]) ? -uq : uq;
                    q = p >>> 13;
                    a = (p9 * q * q) >>> 25;
                    b = (p8 * p) >>> 19;
                    p = ((p + a + b) >>> 8) + (p7 << 4);
                    e.pressure_q24_8 = p[31:0];
                end
            end
            pending_q.push_back(e);
        endfunction

        function void check_result(out_item_t got);
            out_item_t e;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
                return;
            end
            e = pending_q.pop_front();
            if (got.result_kind !== e.result_kind) begin
                $display("%0t: result_kind exp %0d got %0d", $time,
                         e.result_kind, got.result_kind);
                error_count++;
            end
            if (got.temperature_centi !== e.temperature_centi) begin
                $display("%0t: temperature_centi exp %0d got %0d", $time,
                         e.temperature_centi, got.temperature_centi);
                error_count++;
            end
            if (got.pressure_q24_8 !== e.pressure_q24_8) begin
                $display("%0t: pressure_q24_8 exp %h got %h", $time,
                         e.pressure_q24_8, got.pressure_q24_8);
                error_count++;
            end
            if (got.zero_divisor !== e.zero_divisor) begin
                $display("%0t: zero_divisor exp %0d got %0d", $time,
                         e.zero_divisor, got.zero_divisor);
                error_count++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_index_t  cfg_index;
    logic [47:0] cfg_value;

    comp_scoreboard sb;
    bit          idle_on;
    bit          hold_sink;
    longint      cycle_count;

    localparam longint CYCLE_LIMIT = 64'd8_000_000;

    pressure_temperature_compensation_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_value (cfg_value)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // result side: random stall bursts, plus a long hold on request
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_sink) begin
                m_ready <= 1'b0;
                repeat (4000) @(posedge aclk);
                hold_sink = 0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 15);
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // valid stays up between back-to-back items and drops only for idling and while results drain
    task automatic send_item(op_t op, logic [19:0] raw);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data.operation <= op;
        s_data.raw_sample <= raw;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input('{operation: op, raw_sample: raw});
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_coeff(cfg_index_t idx, logic [47:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_value <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.note_config(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // a coefficient word near typical sensor trim, or fully random
    function automatic logic [47:0] pick_coeff(cfg_index_t idx, bit wild);
        logic [47:0] v;
        if (wild) return 48'({$urandom(), $urandom()});
        case (idx)
            CFG_TEMP:    v = {16'($urandom_range(0, 100) - 50),
                              16'($urandom_range(25000, 27000)),
                              16'($urandom_range(26000, 29000))};
            CFG_PRESS_A: v = {16'($urandom_range(0, 8000) - 12000),
                              16'($urandom_range(0, 4000) - 12500),
                              16'($urandom_range(35000, 38000))};
            CFG_PRESS_B: v = {16'($urandom_range(0, 200) - 100),
                              16'($urandom_range(0, 200) - 200),
                              16'($urandom_range(2000, 9000))};
            default:     v = {16'($urandom_range(5000, 7000)),
                              16'($urandom_range(0, 6000) - 17000),
                              16'($urandom_range(0, 40))};
        endcase
        return v;
    endfunction

    task automatic load_set(bit wild);
        cfg_index_t idx;
        for (int i = 0; i < 4; i++) begin
            idx = cfg_index_t'(i);
            write_coeff(idx, pick_coeff(idx, wild));
        end
    endtask

    logic [19:0] raw;
    int          phase;
    cfg_index_t  ci;

    initial begin
        sb = new();
        idle_on = 1;
        hold_sink = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TEMP;
        cfg_value = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset coefficients: pressure with zero divisor, temperature of zeros
        send_item(OP_PRESS, 20'd0);
        send_item(OP_TEMP, 20'd0);
        send_item(OP_TEMP, 20'hFFFFF);
        send_item(OP_PRESS, 20'hFFFFF);
        drain_results();

        // extremes of every coefficient
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 4; i++) begin
                ci = cfg_index_t'(i);
                write_coeff(ci, k == 0 ? 48'hFFFF_FFFF_FFFF :
                                k == 1 ? 48'h8000_8000_FFFF : 48'h7FFF_7FFF_0001);
            end
            send_item(OP_TEMP, 20'hFFFFF);
            send_item(OP_PRESS, 20'h00000);
            send_item(OP_TEMP, 20'h00000);
            send_item(OP_PRESS, 20'hFFFFF);
            drain_results();
        end

        // typical trim, pressure before and after a fresh temperature
        load_set(0);
        send_item(OP_PRESS, 20'h65000);
        send_item(OP_TEMP, 20'h80000);
        send_item(OP_PRESS, 20'h65000);
        send_item(OP_PRESS, 20'h55555);
        send_item(OP_TEMP, 20'hAAAAA);
        drain_results();

        // long receiver hold while items keep coming
        hold_sink = 1;
        for (int i = 0; i < 6; i++) send_item(op_t'(i & 1), 20'($urandom()));
        drain_results();

        for (phase = 0; phase < 14; phase++) begin
            load_set(phase % 4 == 3);
            if (phase >= 11) idle_on = 0;
            for (int i = 0; i < 100; i++) begin
                raw = $urandom_range(0, 4) == 0 ? 20'($urandom())
                                                 : 20'($urandom_range(300000, 600000));
                send_item($urandom_range(0, 2) == 0 ? OP_TEMP : OP_PRESS, raw);
            end
            drain_results();
        end

        if (sb.error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
